/* rtl/lqm_pkg.sv */
// shared types and constants for the linked queue manager
package lqm_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned QidW    = 3;
  localparam int unsigned ElemW   = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SIZE   = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK     = 2'd0,
    STAT_QUEUED = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_ABSENT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_APP_E,
    ST_APP_T,
    ST_APP_H,
    ST_REM_P,
    ST_REM_N
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [QidW-1:0]  queue_id;
    logic [ElemW-1:0] elem_id;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [LenW-1:0]  queue_length;
    logic [ElemW-1:0] head_slot;
    logic             head_present;
  } rsp_t;

  typedef struct packed {
    logic linked;
    logic owner;
    logic link_next;
    logic link_prev;
  } slot_wen_t;

endpackage

/* rtl/linked_queue_manager.sv */
// linked queue manager top: command sequencer over the slot and queue memories
// size queries, refusals, appends to an empty queue and last-element removes answer from
// the decide state; other appends write element, tail and head links, other removes the
// prev and next links; one request at a time under busy, set by the dependent link reads
// and writes; the next request is taken at the edge that takes the response, and the
// receiver cannot stall; after reset busy stays high while slot flags and queues are cleared
module linked_queue_manager #(
  parameter int unsigned NUM_SLOTS  = 64,
  parameter int unsigned NUM_QUEUES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  lqm_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output lqm_pkg::rsp_t rsp_o
);
  import lqm_pkg::*;

  localparam int unsigned SlotW  = $clog2(NUM_SLOTS);
  localparam int unsigned QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned CW     = $clog2(NUM_SLOTS + 1);
  localparam int unsigned ClearN = (NUM_SLOTS > NUM_QUEUES) ? NUM_SLOTS : NUM_QUEUES;
  localparam int unsigned ClrW   = $clog2(ClearN);

  // index folding tables
  logic [SlotW-1:0] elem_map [2**ElemW];
  logic [QW-1:0]    qid_map  [2**QidW];

  for (genvar g = 0; g < 2**ElemW; g++) begin : g_elem_map
    assign elem_map[g] = SlotW'(g % NUM_SLOTS);
  end
  for (genvar g = 0; g < 2**QidW; g++) begin : g_qid_map
    assign qid_map[g] = QW'(g % NUM_QUEUES);
  end

  state_e state_q, state_d;
  logic [ClrW-1:0]  clr_cnt_q;
  logic [CmdW-1:0]  cmd_q;
  logic [QW-1:0]    qid_q;
  logic [SlotW-1:0] eid_q;
  logic [SlotW-1:0] nxt_q;
  logic [SlotW-1:0] prv_q;
  logic             done_q;
  rsp_t             rsp_q;

  logic accept;
  logic clr_last;

  // slot memory port
  slot_wen_t        s_we;
  logic [SlotW-1:0] s_waddr;
  logic             s_wlinked;
  logic [QW-1:0]    s_wowner;
  logic [SlotW-1:0] s_wnext;
  logic [SlotW-1:0] s_wprev;
  logic             s_re;
  logic [SlotW-1:0] s_raddr;
  logic             s_linked;
  logic [QW-1:0]    s_owner;
  logic [SlotW-1:0] s_next;
  logic [SlotW-1:0] s_prev;

  // queue memory port
  logic             q_we;
  logic [QW-1:0]    q_waddr;
  logic             q_wnonempty;
  logic [SlotW-1:0] q_whead;
  logic [CW-1:0]    q_wcount;
  logic             q_re;
  logic [QW-1:0]    q_raddr;
  logic             q_nonempty;
  logic [SlotW-1:0] q_head;
  logic [CW-1:0]    q_count;

  logic             rsp_fire;
  status_e          rsp_status;
  logic             rem_ok;
  logic             rem_last;
  logic [CW-1:0]    cnt_inc;
  logic [CW-1:0]    cnt_dec;
  logic [SlotW+ElemW-1:0] head_ext;
  logic [CW+LenW-1:0]     len_ext;

  lqm_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_QUEUES(NUM_QUEUES)
  ) u_slot_mem (
    .clk_i    (clk_i),
    .we_i     (s_we),
    .waddr_i  (s_waddr),
    .wlinked_i(s_wlinked),
    .wowner_i (s_wowner),
    .wnext_i  (s_wnext),
    .wprev_i  (s_wprev),
    .re_i     (s_re),
    .raddr_i  (s_raddr),
    .rlinked_o(s_linked),
    .rowner_o (s_owner),
    .rnext_o  (s_next),
    .rprev_o  (s_prev)
  );

  lqm_queue_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_QUEUES(NUM_QUEUES)
  ) u_queue_mem (
    .clk_i      (clk_i),
    .we_i       (q_we),
    .waddr_i    (q_waddr),
    .wnonempty_i(q_wnonempty),
    .whead_i    (q_whead),
    .wcount_i   (q_wcount),
    .re_i       (q_re),
    .raddr_i    (q_raddr),
    .rnonempty_o(q_nonempty),
    .rhead_o    (q_head),
    .rcount_o   (q_count)
  );

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && (state_q == ST_IDLE);
  assign clr_last = (clr_cnt_q == ClrW'(ClearN - 1));
  assign rem_ok   = q_nonempty && s_linked && (s_owner == qid_q);
  assign rem_last = (s_next == eid_q);
  assign cnt_inc  = q_count + CW'(1);
  assign cnt_dec  = (q_count != '0) ? (q_count - CW'(1)) : q_count;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        case (cmd_q)
          CMD_APPEND: begin
            if (!s_linked && q_nonempty) begin
              state_d = ST_APP_E;
            end
          end
          CMD_REMOVE: begin
            if (rem_ok && !rem_last) begin
              state_d = ST_REM_P;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_APP_E: state_d = ST_APP_T;
      ST_APP_T: state_d = ST_APP_H;
      ST_APP_H: state_d = ST_IDLE;
      ST_REM_P: state_d = ST_REM_N;
      ST_REM_N: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory control and response
  always_comb begin
    s_we        = '0;
    s_waddr     = eid_q;
    s_wlinked   = 1'b0;
    s_wowner    = qid_q;
    s_wnext     = eid_q;
    s_wprev     = eid_q;
    s_re        = 1'b0;
    s_raddr     = elem_map[req_i.elem_id];
    q_we        = 1'b0;
    q_waddr     = qid_q;
    q_wnonempty = q_nonempty;
    q_whead     = q_head;
    q_wcount    = q_count;
    q_re        = 1'b0;
    q_raddr     = qid_map[req_i.queue_id];
    rsp_fire    = 1'b0;
    rsp_status  = STAT_OK;
    case (state_q)
      ST_CLEAR: begin
        if ({1'b0, clr_cnt_q} < (ClrW + 1)'(NUM_SLOTS)) begin
          s_we.linked = 1'b1;
        end
        s_waddr = clr_cnt_q[SlotW-1:0];
        if ({1'b0, clr_cnt_q} < (ClrW + 1)'(NUM_QUEUES)) begin
          q_we = 1'b1;
        end
        q_waddr     = clr_cnt_q[QW-1:0];
        q_wnonempty = 1'b0;
        q_wcount    = '0;
      end
      ST_IDLE: begin
        s_re = start;
        q_re = start;
      end
      ST_DECIDE: begin
        case (cmd_q)
          CMD_APPEND: begin
            if (s_linked) begin
              rsp_fire   = 1'b1;
              rsp_status = STAT_QUEUED;
            end else if (!q_nonempty) begin
              s_we        = '1;
              s_wlinked   = 1'b1;
              q_we        = 1'b1;
              q_wnonempty = 1'b1;
              q_whead     = eid_q;
              q_wcount    = cnt_inc;
              rsp_fire    = 1'b1;
            end else begin
              s_re    = 1'b1;
              s_raddr = q_head;
            end
          end
          CMD_REMOVE: begin
            if (!q_nonempty) begin
              rsp_fire   = 1'b1;
              rsp_status = STAT_EMPTY;
            end else if (!rem_ok) begin
              rsp_fire   = 1'b1;
              rsp_status = STAT_ABSENT;
            end else begin
              s_we.linked = 1'b1;
              if (rem_last) begin
                q_we        = 1'b1;
                q_wnonempty = 1'b0;
                q_wcount    = cnt_dec;
                rsp_fire    = 1'b1;
              end
            end
          end
          default: rsp_fire = 1'b1;
        endcase
      end
      ST_APP_E: begin
        s_we      = '1;
        s_wlinked = 1'b1;
        s_wnext   = q_head;
        s_wprev   = s_prev;
      end
      ST_APP_T: begin
        s_we.link_next = 1'b1;
        s_waddr        = prv_q;
        s_wnext        = eid_q;
      end
      ST_APP_H: begin
        s_we.link_prev = 1'b1;
        s_waddr        = q_head;
        s_wprev        = eid_q;
        q_we           = 1'b1;
        q_wnonempty    = 1'b1;
        q_wcount       = cnt_inc;
        rsp_fire       = 1'b1;
      end
      ST_REM_P: begin
        s_we.link_next = 1'b1;
        s_waddr        = prv_q;
        s_wnext        = nxt_q;
      end
      ST_REM_N: begin
        s_we.link_prev = 1'b1;
        s_waddr        = nxt_q;
        s_wprev        = prv_q;
        q_we           = 1'b1;
        q_wnonempty    = 1'b1;
        q_whead        = (q_head == eid_q) ? nxt_q : q_head;
        q_wcount       = cnt_dec;
        rsp_fire       = 1'b1;
      end
      default: rsp_fire = 1'b0;
    endcase
  end

  assign head_ext = {ElemW'(0), q_whead};
  assign len_ext  = {LenW'(0), q_wcount};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= rsp_fire;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ClrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.cmd;
      qid_q <= qid_map[req_i.queue_id];
      eid_q <= elem_map[req_i.elem_id];
    end
    if (state_q == ST_DECIDE) begin
      nxt_q <= s_next;
      prv_q <= s_prev;
    end
    if (state_q == ST_APP_E) begin
      prv_q <= s_prev;
    end
    if (rsp_fire) begin
      rsp_q.status       <= rsp_status;
      rsp_q.queue_length <= len_ext[LenW-1:0];
      rsp_q.head_slot    <= q_wnonempty ? head_ext[ElemW-1:0] : '0;
      rsp_q.head_present <= q_wnonempty;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/lqm_slot_mem.sv */
// per-slot memory with field write enables: linked flag, owner, next and prev links
module lqm_slot_mem #(
  parameter int unsigned NUM_SLOTS  = 64,
  parameter int unsigned NUM_QUEUES = 8,
  localparam int unsigned SlotW = $clog2(NUM_SLOTS),
  localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic                  clk_i,
  input  lqm_pkg::slot_wen_t    we_i,
  input  logic [SlotW-1:0]      waddr_i,
  input  logic                  wlinked_i,
  input  logic [QW-1:0]         wowner_i,
  input  logic [SlotW-1:0]      wnext_i,
  input  logic [SlotW-1:0]      wprev_i,
  input  logic                  re_i,
  input  logic [SlotW-1:0]      raddr_i,
  output logic                  rlinked_o,
  output logic [QW-1:0]         rowner_o,
  output logic [SlotW-1:0]      rnext_o,
  output logic [SlotW-1:0]      rprev_o
);
  import lqm_pkg::*;

  logic             linked_mem [NUM_SLOTS];
  logic [QW-1:0]    owner_mem  [NUM_SLOTS];
  logic [SlotW-1:0] next_mem   [NUM_SLOTS];
  logic [SlotW-1:0] prev_mem   [NUM_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i.linked) begin
      linked_mem[waddr_i] <= wlinked_i;
    end
    if (we_i.owner) begin
      owner_mem[waddr_i] <= wowner_i;
    end
    if (we_i.link_next) begin
      next_mem[waddr_i] <= wnext_i;
    end
    if (we_i.link_prev) begin
      prev_mem[waddr_i] <= wprev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rlinked_o <= linked_mem[raddr_i];
      rowner_o  <= owner_mem[raddr_i];
      rnext_o   <= next_mem[raddr_i];
      rprev_o   <= prev_mem[raddr_i];
    end
  end

endmodule

/* rtl/lqm_queue_mem.sv */
// per-queue memory: nonempty flag, head slot and element count
module lqm_queue_mem #(
  parameter int unsigned NUM_SLOTS  = 64,
  parameter int unsigned NUM_QUEUES = 8,
  localparam int unsigned SlotW = $clog2(NUM_SLOTS),
  localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int unsigned CW    = $clog2(NUM_SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [QW-1:0]    waddr_i,
  input  logic             wnonempty_i,
  input  logic [SlotW-1:0] whead_i,
  input  logic [CW-1:0]    wcount_i,
  input  logic             re_i,
  input  logic [QW-1:0]    raddr_i,
  output logic             rnonempty_o,
  output logic [SlotW-1:0] rhead_o,
  output logic [CW-1:0]    rcount_o
);

  logic [CW+SlotW:0] queue_mem [NUM_QUEUES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      queue_mem[waddr_i] <= {wnonempty_i, whead_i, wcount_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      {rnonempty_o, rhead_o, rcount_o} <= queue_mem[raddr_i];
    end
  end

endmodule
